@@ hdl/crap8_pkg.sv @@
// shared types, constants and helpers of the crap8 word hash
`default_nettype none

package crap8_pkg;

   localparam int WORD_W  = 32;
   localparam int VB_W    = 3;
   localparam int PROD_W  = 2 * WORD_W;
   localparam int TDATA_W = 104;

   localparam logic [WORD_W-1:0] M_MUL = 32'h83d2e73b;
   localparam logic [WORD_W-1:0] N_MUL = 32'h97e1cc59;

   // request tdata field positions
   localparam int WORD_LSB = 0;
   localparam int VB_LSB   = WORD_LSB + WORD_W;
   localparam int SEED_LSB = VB_LSB + VB_W;
   localparam int LEN_LSB  = SEED_LSB + WORD_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_H,
      ST_MUL_W,
      ST_MIX,
      ST_FOLD_MUL,
      ST_FOLD
   } state_type;

   typedef enum logic [1:0] {
      SEL_H,
      SEL_WORD,
      SEL_FOLD
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        h_take_prod;
      logic        mix;
      logic        fold;
   } dp_cmd_type;

   typedef struct packed {
      logic nz;
      logic last;
      logic out_busy;
   } dp_status_type;

   // keep only the bytes in use, five to seven count as four
   function automatic logic [WORD_W-1:0] mask_word(input logic [WORD_W-1:0] w,
                                                   input logic [VB_W-1:0] vb);
      logic [WORD_W-1:0] r;
      unique case (vb)
         3'd1:    r = w & 32'h0000_00ff;
         3'd2:    r = w & 32'h0000_ffff;
         3'd3:    r = w & 32'h00ff_ffff;
         default: r = w;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/crap8_ctrl.sv @@
// sequencer of the crap8 word hash
`default_nettype none

module crap8_ctrl
   import crap8_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output      logic          in_ready,
   input  wire dp_status_type status,
   output      dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) state_in = ST_MUL_H;
         end
         ST_MUL_H: begin
            if (status.nz) state_in = ST_MUL_W;
            else if (status.last) state_in = ST_FOLD_MUL;
            else state_in = ST_IDLE;
         end
         ST_MUL_W: state_in = ST_MIX;
         ST_MIX: begin
            state_in = status.last ? ST_FOLD_MUL : ST_IDLE;
         end
         ST_FOLD_MUL: state_in = ST_FOLD;
         ST_FOLD: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready        = 1'b0;
      cmd             = '0;
      cmd.mul_sel     = SEL_H;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         ST_MUL_H: begin
            cmd.mul_en  = status.nz;
            cmd.mul_sel = SEL_H;
         end
         ST_MUL_W: begin
            cmd.mul_en      = 1'b1;
            cmd.mul_sel     = SEL_WORD;
            cmd.h_take_prod = 1'b1;
         end
         ST_MIX: cmd.mix = 1'b1;
         ST_FOLD_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = SEL_FOLD;
         end
         ST_FOLD: cmd.fold = !status.out_busy;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

@@ hdl/crap8_dp.sv @@
// datapath of the crap8 word hash: state, shared multiplier, result register
`default_nettype none

module crap8_dp
   import crap8_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [TDATA_W-1:0] in_data,
   input  wire logic               in_first,
   input  wire logic               in_last,
   input  wire dp_cmd_type         cmd,
   output      dp_status_type      status,
   output      logic               out_valid,
   input  wire logic               out_ready,
   output      logic [WORD_W-1:0]  out_digest
);

   logic [WORD_W-1:0] h_ff, h_in, k_ff, k_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              nz_ff, nz_in, last_ff, last_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] digest_ff, digest_in;

   logic [WORD_W-1:0] f_word, f_seed, f_len;
   logic [VB_W-1:0]   f_vb;
   logic [WORD_W-1:0] mul_a, mul_b, folded;

   assign f_word = in_data[WORD_LSB +: WORD_W];
   assign f_vb   = in_data[VB_LSB +: VB_W];
   assign f_seed = in_data[SEED_LSB +: WORD_W];
   assign f_len  = in_data[LEN_LSB +: WORD_W];

   always_comb begin
      unique case (cmd.mul_sel)
         SEL_WORD: mul_a = word_ff;
         SEL_FOLD: mul_a = h_ff ^ k_ff;
         default:  mul_a = h_ff;
      endcase
      mul_b   = (cmd.mul_sel == SEL_FOLD) ? N_MUL : M_MUL;
      prod_in = cmd.mul_en ? (PROD_W'(mul_a) * PROD_W'(mul_b)) : prod_ff;
   end

   assign folded = k_ff ^ prod_ff[WORD_W-1:0] ^ prod_ff[PROD_W-1:WORD_W];

   always_comb begin
      h_in    = h_ff;
      k_in    = k_ff;
      word_in = word_ff;
      nz_in   = nz_ff;
      last_in = last_ff;
      if (cmd.load) begin
         word_in = mask_word(f_word, f_vb);
         nz_in   = (f_vb != '0);
         last_in = in_last;
         if (in_first) begin
            h_in = f_len + f_seed;
            k_in = N_MUL + f_len;
         end
      end
      if (cmd.h_take_prod) h_in = prod_ff[WORD_W-1:0];
      if (cmd.mix) begin
         k_in = k_ff ^ prod_ff[WORD_W-1:0];
         h_in = h_ff ^ prod_ff[PROD_W-1:WORD_W];
      end
      if (cmd.fold) k_in = folded;
   end

   always_comb begin
      digest_in    = digest_ff;
      out_valid_in = out_valid_ff && !out_ready;
      if (cmd.fold) begin
         digest_in    = folded;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff         <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         h_ff         <= h_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      nz_ff     <= nz_in;
      last_ff   <= last_in;
      prod_ff   <= prod_in;
      digest_ff <= digest_in;
   end

   assign status.nz       = nz_ff;
   assign status.last     = last_ff;
   assign status.out_busy = out_valid_ff && !out_ready;
   assign out_valid       = out_valid_ff;
   assign out_digest      = digest_ff;

endmodule

`default_nettype wire

@@ hdl/crap8_word_hash.sv @@
// top level of the crap8 word hash: sequencer plus datapath
//
// channel   dir  handshake                tdata / tuser / tlast
// req_      in   req_tvalid/req_tready    word, valid bytes, seed, length / first / last
// rsp_      out  rsp_tvalid/rsp_tready    digest / - / -
//
// an item with valid bytes passes the states mul_h, mul_w and mix before the next ready,
// an item with zero valid bytes passes mul_h only; a last item adds fold_mul and the fold
// one shared 32x32 multiplier with a registered 64-bit product does the steps in order:
// h*m, then word*m, then the mix, then (h^k)*n and the fold
// reset (synchronous, active high) clears h, k, the sequencer and rsp_tvalid
// the digest sits in an output register; new items are taken while it waits,
// only the fold of the next digest stalls until it has been transferred
`default_nettype none

module crap8_word_hash
   import crap8_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request stream
   input  wire logic               req_tvalid,
   output      logic               req_tready,
   // [31:0] data_word, [34:32] valid_bytes, [66:35] seed, [98:67] msg_len,
   // [103:99] zero
   input  wire logic [TDATA_W-1:0] req_tdata,
   // [0] first_word
   input  wire logic               req_tuser,
   input  wire logic               req_tlast,   // last_word
   // response stream
   output      logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   // [31:0] digest
   output      logic [WORD_W-1:0]  rsp_tdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: walks each item through the shared multiplier
   crap8_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   // datapath: mix state, multiplier and digest register
   crap8_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .in_data    (req_tdata),
      .in_first   (req_tuser),
      .in_last    (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_digest (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ hdl/crap8_checker.sv @@
// port-level checks of the crap8 word hash and their bind
`default_nettype none

module crap8_checker
   import crap8_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_tvalid,
   input wire logic               req_tready,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [WORD_W-1:0]  rsp_tdata
);

   // a stalled digest stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("digest changed or dropped while stalled");

   // one item at a time: no transfer in the cycle after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in work");

   // a new digest appears only out of the fold, when requests are held off
   a_digest_from_fold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("digest appeared outside the fold");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind crap8_word_hash crap8_checker u_crap8_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench of the crap8 word hash, stream in and digest out
`timescale 1ns / 1ps

module testbench;
   import crap8_pkg::*;

   localparam int TOTAL_ITEMS  = 720;   // directed rows plus random items
   localparam int CALM_ITEMS   = 100;   // tail of the run without idling
   localparam int LONG_HOLD    = 250;   // receiver hold-off, in cycles
   localparam int STALL_LIMIT  = 2000;  // cycles with no transfer before giving up
   localparam int DRAIN_CYCLES = 20;    // wait after the last digest, for anything stray

   // one message word as the sender sees it
   typedef struct {
      logic [WORD_W-1:0] word;
      logic [VB_W-1:0]   nbytes;
      logic              first;
      logic              last;
      logic [WORD_W-1:0] seed;
      logic [WORD_W-1:0] len;
      bit                known;         // digest typed in by hand
      logic [WORD_W-1:0] known_digest;
   } hash_item_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   // [31:0] data_word, [34:32] valid_bytes, [66:35] seed, [98:67] msg_len, [103:99] zero
   logic [TDATA_W-1:0] req_tdata  = '0;
   // [0] first_word
   logic               req_tuser  = 1'b0;
   logic               req_tlast  = 1'b0;   // last_word
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   // [31:0] digest
   logic [WORD_W-1:0]  rsp_tdata;

   // running hash state of the predictor
   logic [WORD_W-1:0]  acc_h = '0;
   logic [WORD_W-1:0]  acc_k = '0;

   logic [WORD_W-1:0]  pending_digests[$];
   int                 fail_count = 0;
   int                 items_sent = 0;
   int                 sink_hold  = 0;    // set by the stimulus, served by the receiver
   bit                 calm       = 1'b0; // no idling on either side
   bit                 jitter     = 1'b1; // idling allowed for this message
   bit                 burst      = 1'b0; // sender keeps offering back to back

   crap8_word_hash dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   function automatic hash_item_type make_item(input logic [WORD_W-1:0] word,
                                               input logic [VB_W-1:0] nbytes,
                                               input logic first, input logic last,
                                               input logic [WORD_W-1:0] seed,
                                               input logic [WORD_W-1:0] len,
                                               input bit known,
                                               input logic [WORD_W-1:0] known_digest);
      hash_item_type it;
      it.word         = word;
      it.nbytes       = nbytes;
      it.first        = first;
      it.last         = last;
      it.seed         = seed;
      it.len          = len;
      it.known        = known;
      it.known_digest = known_digest;
      return it;
   endfunction

   // absorb one word into the running state; returns 1 with the digest on a last word
   function automatic bit crap8_absorb(input hash_item_type it,
                                       output logic [WORD_W-1:0] digest_out);
      logic [WORD_W-1:0] w;
      logic [PROD_W-1:0] prod;
      w          = it.word;
      digest_out = '0;
      // a first word reloads both halves of the state
      if (it.first) begin
         acc_h = it.len + it.seed;
         acc_k = N_MUL + it.len;
      end
      // zero valid bytes leaves the state alone, five to seven mean a full word
      if (it.nbytes != 0) begin
         if (it.nbytes < 4)
            w = w & ((32'h1 << (8 * it.nbytes)) - 32'h1);
         acc_h = acc_h * M_MUL;
         prod  = PROD_W'(w) * PROD_W'(M_MUL);
         acc_k = acc_k ^ prod[WORD_W-1:0];
         acc_h = acc_h ^ prod[PROD_W-1:WORD_W];
      end
      // fold of h into k gives the digest, h is kept as it is
      if (it.last) begin
         prod       = PROD_W'(acc_h ^ acc_k) * PROD_W'(N_MUL);
         acc_k      = acc_k ^ prod[WORD_W-1:0] ^ prod[PROD_W-1:WORD_W];
         digest_out = acc_k;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // offer one word, hold it until the transfer, then predict
   task automatic push_item(input hash_item_type it);
      logic [TDATA_W-1:0] d;
      logic [WORD_W-1:0]  dig;
      d = '0;
      d[WORD_LSB +: WORD_W] = it.word;
      d[VB_LSB   +: VB_W]   = it.nbytes;
      d[SEED_LSB +: WORD_W] = it.seed;
      d[LEN_LSB  +: WORD_W] = it.len;
      // random gap before the word, valid goes low only for the gap
      if (jitter && !calm && !burst && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= it.first;
      req_tlast  <= it.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // transfer happened at this edge
      if (crap8_absorb(it, dig))
         pending_digests.push_back(it.known ? it.known_digest : dig);
      items_sent++;
   endtask

   // receiver pacing: random stalls, one long hold-off on request
   initial begin : sink_pacing
      forever begin
         @(posedge clock);
         if (sink_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (sink_hold) @(posedge clock);
            sink_hold = 0;
         end else if (jitter && !calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // digest check against the oldest pending message
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_digests.size() == 0) begin
            $display("%0t: digest %h with no message pending", $time, rsp_tdata);
            fail_count++;
         end else begin
            if (rsp_tdata !== pending_digests[0]) begin
               $display("%0t: digest mismatch, expected %h, actual %h",
                        $time, pending_digests[0], rsp_tdata);
               fail_count++;
            end
            void'(pending_digests.pop_front());
         end
      end
   end

   // give up when neither side moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      hash_item_type     directed_rows[$];
      int                total_bytes;
      int                nwords;
      int                kind;
      bit                broken;
      bit                pressure_done;
      logic [WORD_W-1:0] seed;
      logic [WORD_W-1:0] len_field;
      logic [VB_W-1:0]   vb;

      pressure_done = 1'b0;

      // state is zero after reset, so the fold of nothing gives zero
      directed_rows.push_back(make_item('0, 3'd0, 1'b0, 1'b1, '0, '0, 1'b1, 32'h0));
      // empty message with seed n and length zero: h equals k, fold adds nothing
      directed_rows.push_back(make_item('0, 3'd0, 1'b1, 1'b1, N_MUL, '0, 1'b1, N_MUL));
      // empty message, seed and length at the top
      directed_rows.push_back(make_item('1, 3'd0, 1'b1, 1'b1, '1, '1, 1'b0, '0));
      // single full words at both extremes, length mismatch on the second
      directed_rows.push_back(make_item('1, 3'd4, 1'b1, 1'b1, '0, 32'd4, 1'b0, '0));
      directed_rows.push_back(make_item('0, 3'd4, 1'b1, 1'b1, '1, '0, 1'b0, '0));
      // eleven byte message, short last word gets masked
      directed_rows.push_back(make_item(32'h0302_0100, 3'd4, 1'b1, 1'b0,
                                        32'h1234_5678, 32'd11, 1'b0, '0));
      directed_rows.push_back(make_item(32'h0706_0504, 3'd4, 1'b0, 1'b0, '1, '1, 1'b0, '0));
      directed_rows.push_back(make_item('1, 3'd3, 1'b0, 1'b1, '0, '0, 1'b0, '0));
      // one and two byte messages
      directed_rows.push_back(make_item('1, 3'd1, 1'b1, 1'b1, 32'h5555_5555, 32'd1, 1'b0, '0));
      directed_rows.push_back(make_item(32'ha5a5_a5a5, 3'd2, 1'b1, 1'b1,
                                        32'haaaa_aaaa, 32'd2, 1'b0, '0));
      // too many valid bytes counts as a full word
      directed_rows.push_back(make_item(32'h1234_5678, 3'd5, 1'b1, 1'b1, '0, 32'd4, 1'b0, '0));
      directed_rows.push_back(make_item(32'h8765_4321, 3'd6, 1'b1, 1'b1, '0, 32'd4, 1'b0, '0));
      directed_rows.push_back(make_item('1, 3'd7, 1'b1, 1'b1, '1, 32'd4, 1'b0, '0));
      // no first mark: keep mixing from the folded state
      directed_rows.push_back(make_item(32'hdead_beef, 3'd4, 1'b0, 1'b0, '1, '1, 1'b0, '0));
      directed_rows.push_back(make_item(32'hcafe_f00d, 3'd3, 1'b0, 1'b1, '0, '0, 1'b0, '0));
      // zero valid bytes in the middle and on the last word
      directed_rows.push_back(make_item(32'h0bad_cafe, 3'd0, 1'b1, 1'b0,
                                        32'h0f0f_0f0f, 32'd8, 1'b0, '0));
      directed_rows.push_back(make_item(32'h0123_4567, 3'd4, 1'b0, 1'b0, '0, '0, 1'b0, '0));
      directed_rows.push_back(make_item('0, 3'd0, 1'b0, 1'b0, '0, '0, 1'b0, '0));
      directed_rows.push_back(make_item(32'h89ab_cdef, 3'd4, 1'b0, 1'b0, '0, '0, 1'b0, '0));
      directed_rows.push_back(make_item(32'h7fff_ffff, 3'd0, 1'b0, 1'b1, '0, '0, 1'b0, '0));

      // reset first, then start offering words
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         push_item(directed_rows[i]);

      // sender pauses until every digest is back
      req_tvalid <= 1'b0;
      while (pending_digests.size() != 0) @(posedge clock);

      while (items_sent < TOTAL_ITEMS) begin
         calm   = (items_sent >= TOTAL_ITEMS - CALM_ITEMS);
         jitter = ($urandom_range(0, 3) != 0);

         if (!pressure_done && items_sent >= 300) begin
            // receiver holds off while short messages keep coming: the output
            // register fills and the next fold stalls the input
            pressure_done = 1'b1;
            burst         = 1'b1;
            sink_hold     = LONG_HOLD;
            repeat (12)
               push_item(make_item($urandom, VB_W'($urandom_range(0, 4)), 1'b1, 1'b1,
                                   $urandom, $urandom, 1'b0, '0));
            burst = 1'b0;
            req_tvalid <= 1'b0;
            while (pending_digests.size() != 0) @(posedge clock);
         end

         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            // noise: any field value, marks at random
            push_item(make_item($urandom, VB_W'($urandom_range(0, 7)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                $urandom, $urandom, 1'b0, '0));
         end else if (kind == 1) begin
            // empty message
            push_item(make_item($urandom, 3'd0, 1'b1, 1'b1, $urandom,
                                ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom, 1'b0, '0));
         end else begin
            // well-formed message, mostly short, now and then long
            total_bytes = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 256)
                                                       : $urandom_range(1, 40);
            nwords      = (total_bytes + 3) / 4;
            len_field   = ($urandom_range(0, 7) == 0) ? $urandom : WORD_W'(total_bytes);
            seed        = $urandom;
            broken      = ($urandom_range(0, 11) == 0);  // last mark dropped
            for (int i = 0; i < nwords; i++) begin
               vb = (i == nwords - 1) ? VB_W'(total_bytes - 4 * (nwords - 1)) : 3'd4;
               if (i == 0)
                  push_item(make_item($urandom, vb, 1'b1, (nwords == 1) && !broken,
                                      seed, len_field, 1'b0, '0));
               else
                  push_item(make_item($urandom, vb, 1'b0, (i == nwords - 1) && !broken,
                                      $urandom, $urandom, 1'b0, '0));
            end
         end
      end

      // drain: all digests back, then a last wait for anything stray
      req_tvalid <= 1'b0;
      while (pending_digests.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_digests.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/crap8_pkg.sv
hdl/crap8_ctrl.sv
hdl/crap8_dp.sv
hdl/crap8_word_hash.sv
hdl/crap8_checker.sv
tb/testbench.sv
